// ===== sv/mfau_pkg.sv =====
// ---------------------------------------------------------------------------
// mfau_pkg: shared definitions for the motor feedback angle unwrap block
// Frame identifiers, register indexes, reset values and the structs that
// travel between the front end, the queue and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package mfau_pkg;

  localparam int MOTOR_SLOTS_DEF = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [10:0] FIRST_ID = 11'h201;
  localparam logic [10:0] LAST_ID  = 11'h208;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_RESOLUTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SCALE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_DIVISOR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_COUNT       = 3'd5;

  localparam logic [15:0] RST_WRAP_THRESHOLD    = 16'd4096;
  localparam logic [16:0] RST_SENSOR_RESOLUTION = 17'd8192;
  localparam logic [23:0] RST_WRAP_LIMIT        = 24'd294912;
  localparam logic [31:0] RST_ANGLE_SCALE       = 32'd20480;
  localparam logic [7:0]  RST_SPEED_DIVISOR     = 8'd36;
  localparam logic [3:0]  RST_MOTOR_COUNT       = 4'd8;

  typedef struct packed {
    logic [15:0] wrap_threshold;
    logic [16:0] sensor_resolution;
    logic [23:0] wrap_limit;
    logic [31:0] angle_scale;
    logic [7:0]  speed_divisor;
    logic [3:0]  motor_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         slot;
    logic [15:0]        angle_word;
    logic signed [15:0] speed_word;
    logic signed [15:0] current_word;
  } item_t;

  typedef struct packed {
    logic [2:0]         slot;
    logic               seeded_only;
    logic [23:0]        turn_count;
    logic [31:0]        angle_out;
    logic signed [15:0] speed_out;
    logic signed [15:0] current_out;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/mfau_fifo.sv =====
// ---------------------------------------------------------------------------
// mfau_fifo: short queue between front end and back end
// Register-based first-in first-out buffer with a fill count.
// ---------------------------------------------------------------------------
`default_nettype none

module mfau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mfau_front.sv =====
// ---------------------------------------------------------------------------
// mfau_front: frame classifier
// Accepts feedback words, keeps those whose identifier names a motor slot
// and drops all others.
// ---------------------------------------------------------------------------
`default_nettype none

module mfau_front #(
  parameter int MOTOR_SLOTS = mfau_pkg::MOTOR_SLOTS_DEF
) (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [10:0]        frame_id,
  input  wire logic [15:0]        angle_word,
  input  wire logic signed [15:0] speed_word,
  input  wire logic signed [15:0] current_word,
  input  wire logic               queue_full,
  output logic                    push,
  output mfau_pkg::item_t         item
);

  logic [10:0] offset;
  logic        id_ok;
  logic        slot_ok;

  assign offset  = frame_id - mfau_pkg::FIRST_ID;
  assign id_ok   = (frame_id >= mfau_pkg::FIRST_ID) && (frame_id <= mfau_pkg::LAST_ID);
  assign slot_ok = (offset < 11'(MOTOR_SLOTS));

  // Dropped words are still taken while the queue has room; they take no queue entry.
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full && id_ok && slot_ok;

  always_comb begin
    item.slot         = offset[2:0];
    item.angle_word   = angle_word;
    item.speed_word   = speed_word;
    item.current_word = current_word;
  end

endmodule

`default_nettype wire

// ===== sv/mfau_back.sv =====
// ---------------------------------------------------------------------------
// mfau_back: per-slot angle unwrap, scaling and speed division
// Sequencer that updates the slot accumulator, folds it, scales it with a
// shared 32x17 multiplier in two passes and divides the speed bit by bit
// (a seeding frame skips the update, the fold and the division).
`default_nettype none

module mfau_back #(
  parameter int MOTOR_SLOTS = mfau_pkg::MOTOR_SLOTS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mfau_pkg::cfg_t  cfg,
  input  wire logic            queue_empty,
  input  wire mfau_pkg::item_t queue_item,
  output logic                 pop,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output mfau_pkg::result_t    res
);

  localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_STEP, ST_FOLD_HI, ST_FOLD_LO, ST_MUL_LO, ST_MUL_HI, ST_DIV, ST_OUT
  } state_t;

  state_t state;

  logic [15:0]        prev_angle [MOTOR_SLOTS];
  logic signed [31:0] acc_store  [MOTOR_SLOTS];
  logic [MOTOR_SLOTS-1:0] seeded;

  mfau_pkg::item_t    cur;
  logic [SLOT_W-1:0]  idx;
  logic               seed;
  logic [15:0]        prev_r;
  logic signed [31:0] acc_r;
  logic [39:0]        prod;
  logic [8:0]         rem;
  logic [15:0]        quo;
  logic [3:0]         div_cnt;
  logic               speed_neg;
  logic [7:0]         divisor;

  logic [SLOT_W-1:0]  in_idx;
  logic signed [17:0] diff;
  logic signed [17:0] thr_s;
  logic signed [18:0] delta;
  logic signed [31:0] lim_s;
  logic signed [31:0] acc_folded;
  logic [15:0]        mul_b;
  logic signed [48:0] mul_p;
  logic [8:0]         trial;
  logic [15:0]        speed_mag;
  logic               out_load;

  assign in_idx = SLOT_W'(queue_item.slot);
  assign pop    = (state == ST_IDLE) && !queue_empty;

  always_comb begin
    diff  = $signed({2'b00, cur.angle_word}) - $signed({2'b00, prev_r});
    thr_s = $signed({2'b00, cfg.wrap_threshold});
    if (diff > thr_s) begin
      delta = 19'(diff) - $signed({2'b00, cfg.sensor_resolution});
    end else if (diff < -thr_s) begin
      delta = 19'(diff) + $signed({2'b00, cfg.sensor_resolution});
    end else begin
      delta = 19'(diff);
    end
  end

  assign lim_s      = $signed({8'h00, cfg.wrap_limit});
  assign acc_folded = (acc_r < 0) ? acc_r + lim_s : acc_r;

  // One multiplier serves both halves of the scale factor.
  assign mul_b = (state == ST_MUL_HI) ? cfg.angle_scale[31:16] : cfg.angle_scale[15:0];
  assign mul_p = acc_r * $signed({1'b0, mul_b});

  assign trial     = {rem[7:0], quo[15]};
  assign speed_mag = queue_item.speed_word[15] ? 16'(-queue_item.speed_word)
                                               : queue_item.speed_word;

  // The output register takes a new word when it is empty or being drained.
  assign out_load = (state == ST_OUT) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      seeded    <= '0;
      for (int i = 0; i < MOTOR_SLOTS; i++) begin
        prev_angle[i] <= '0;
        acc_store[i]  <= '0;
      end
    end else begin
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!queue_empty) begin
            cur       <= queue_item;
            idx       <= in_idx;
            prev_r    <= prev_angle[in_idx];
            acc_r     <= acc_store[in_idx];
            seed      <= !seeded[in_idx] && ({1'b0, queue_item.slot} < cfg.motor_count);
            rem       <= '0;
            quo       <= speed_mag;
            div_cnt   <= '0;
            speed_neg <= queue_item.speed_word[15];
            divisor   <= (cfg.speed_divisor == '0) ? 8'd1 : cfg.speed_divisor;
            state     <= ST_STEP;
          end
        end
        ST_STEP: begin
          prev_angle[idx] <= cur.angle_word;
          seeded[idx]     <= 1'b1;
          if (seed) begin
            state <= ST_MUL_LO;
          end else begin
            acc_r <= acc_r + 32'(delta);
            state <= ST_FOLD_HI;
          end
        end
        ST_FOLD_HI: begin
          if (acc_r > lim_s) begin
            acc_r <= acc_r - lim_s;
          end
          state <= ST_FOLD_LO;
        end
        ST_FOLD_LO: begin
          acc_r          <= acc_folded;
          acc_store[idx] <= acc_folded;
          state          <= ST_MUL_LO;
        end
        ST_MUL_LO: begin
          prod  <= mul_p[39:0];
          state <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          prod  <= prod + {mul_p[23:0], 16'h0000};
          state <= seed ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (trial >= {1'b0, divisor}) begin
            rem <= trial - {1'b0, divisor};
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[14:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 4'd15) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            res.slot        <= cur.slot;
            res.seeded_only <= seed;
            res.turn_count  <= acc_r[23:0];
            res.angle_out   <= prod[39:8];
            res.speed_out   <= seed ? 16'sd0 : (speed_neg ? -$signed(quo) : $signed(quo));
            res.current_out <= seed ? 16'sd0 : cur.current_word;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/motor_feedback_angle_unwrap.sv =====
// ---------------------------------------------------------------------------
// motor_feedback_angle_unwrap: multi-turn unwrap of motor feedback frames
// Front end classifies frames, a two-entry queue decouples it from the
// back end that unwraps, scales and divides, and an output register holds
// the result word.
// ---------------------------------------------------------------------------
// Sequence: a seeding frame passes the step, multiply and output states;
// an unwrapping frame also passes the fold states and the 16-step speed
// divider. The back-end sequencer takes a new frame only once the last has
// left it; dropped identifiers are taken while the queue has room.
// Reset (synchronous): registers return to defaults, all slots unseeded,
// accumulators and previous angles cleared, queue and output emptied.
`default_nettype none

module motor_feedback_angle_unwrap #(
  parameter int MOTOR_SLOTS = mfau_pkg::MOTOR_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // angle_word, speed_word, current_word
  input  wire logic [10:0] s_axis_tuser,  // frame_id
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,  // turn_count, angle_out, speed_out, current_out
  output logic [3:0]       m_axis_tuser,  // slot, seeded_only
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [mfau_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  mfau_pkg::cfg_t    cfg;
  mfau_pkg::item_t   push_item;
  mfau_pkg::item_t   pop_item;
  mfau_pkg::result_t res;
  logic              push;
  logic              pop;
  logic              queue_full;
  logic              queue_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_threshold    <= mfau_pkg::RST_WRAP_THRESHOLD;
      cfg.sensor_resolution <= mfau_pkg::RST_SENSOR_RESOLUTION;
      cfg.wrap_limit        <= mfau_pkg::RST_WRAP_LIMIT;
      cfg.angle_scale       <= mfau_pkg::RST_ANGLE_SCALE;
      cfg.speed_divisor     <= mfau_pkg::RST_SPEED_DIVISOR;
      cfg.motor_count       <= mfau_pkg::RST_MOTOR_COUNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        mfau_pkg::CFG_WRAP_THRESHOLD:    cfg.wrap_threshold    <= cfg_data[15:0];
        mfau_pkg::CFG_SENSOR_RESOLUTION: cfg.sensor_resolution <= cfg_data[16:0];
        mfau_pkg::CFG_WRAP_LIMIT:        cfg.wrap_limit        <= cfg_data[23:0];
        mfau_pkg::CFG_ANGLE_SCALE:       cfg.angle_scale       <= cfg_data;
        mfau_pkg::CFG_SPEED_DIVISOR:     cfg.speed_divisor     <= cfg_data[7:0];
        mfau_pkg::CFG_MOTOR_COUNT:       cfg.motor_count       <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  mfau_front #(
    .MOTOR_SLOTS (MOTOR_SLOTS)
  ) u_front (
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .frame_id     (s_axis_tuser),
    .angle_word   (s_axis_tdata[15:0]),
    .speed_word   (s_axis_tdata[31:16]),
    .current_word (s_axis_tdata[47:32]),
    .queue_full   (queue_full),
    .push         (push),
    .item         (push_item)
  );

  mfau_fifo #(
    .WIDTH ($bits(mfau_pkg::item_t)),
    .DEPTH (mfau_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_item),
    .empty     (queue_empty)
  );

  mfau_back #(
    .MOTOR_SLOTS (MOTOR_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .queue_item  (pop_item),
    .pop         (pop),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res         (res)
  );

  assign m_axis_tdata = {res.current_out, res.speed_out, res.angle_out, res.turn_count};
  assign m_axis_tuser = {res.seeded_only, res.slot};

endmodule

`default_nettype wire

// ===== sv/mfau_checker.sv =====
// ---------------------------------------------------------------------------
// mfau_checker: port-level checks for the angle unwrap block
// Watches the result stream for hold, reset, seeding and slot range behavior.
// ---------------------------------------------------------------------------
`default_nettype none

module mfau_checker #(
  parameter int MOTOR_SLOTS = mfau_pkg::MOTOR_SLOTS_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic [3:0]  m_axis_tuser
);

  // A stalled result word must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A seeding word reports zero speed and current.
  a_seed_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tdata[87:56] == 32'h0)
    else $error("seeding word carries speed or current");

  // Reported slot is always one that exists.
  a_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 32'(m_axis_tuser[2:0]) < MOTOR_SLOTS)
    else $error("slot beyond the slot count");

endmodule

bind motor_feedback_angle_unwrap mfau_checker #(.MOTOR_SLOTS(MOTOR_SLOTS)) u_checker (.*);

`default_nettype wire
